// ===== hdl/pgvg_pkg.sv =====
// Shared types and constants for the plane grid vertex generator.
package pgvg_pkg;

    localparam int COORD_W     = 12;
    localparam int SAMP_W      = 13;
    localparam int SIZE_W      = 31;
    localparam int POS_W       = 32;
    localparam int TEX_W       = 17;
    localparam int IDX_W       = 24;
    localparam int CODE_W      = 3;
    localparam int FRAC_BITS   = 16;
    localparam int MAX_SAMPLES = 4096;

    localparam int NUM_STAGES      = 6;
    localparam int STEPS_PER_STAGE = 3;
    localparam int TEX_STEPS       = FRAC_BITS + 1;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_AXIS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_OFFSET = 3'd5;

    localparam logic [2:0] AX_XY = 3'd0;
    localparam logic [2:0] AX_YX = 3'd1;
    localparam logic [2:0] AX_YZ = 3'd2;
    localparam logic [2:0] AX_ZY = 3'd3;
    localparam logic [2:0] AX_ZX = 3'd4;
    localparam logic [2:0] AX_XZ = 3'd5;

    localparam logic [CODE_W-1:0] NRM_POS_Z = 3'd0;
    localparam logic [CODE_W-1:0] NRM_NEG_Z = 3'd1;
    localparam logic [CODE_W-1:0] NRM_POS_X = 3'd2;
    localparam logic [CODE_W-1:0] NRM_NEG_X = 3'd3;
    localparam logic [CODE_W-1:0] NRM_NEG_Y = 3'd4;
    localparam logic [CODE_W-1:0] NRM_POS_Y = 3'd5;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_SMALL = 2'd1,
        ST_OUTSIDE   = 2'd2
    } status_t;

    typedef struct packed {
        logic [COORD_W-1:0]      col;
        logic [COORD_W-1:0]      row;
        status_t                 status;
        logic                    quad;
        logic [SIZE_W-1:0]       ai;
        logic [SIZE_W-1:0]       bj;
        logic [IDX_W-1:0]        vid;
        logic signed [POS_W-1:0] ca_ai;
        logic signed [POS_W-1:0] cb_ai;
        logic signed [POS_W-1:0] ca_bj;
        logic signed [POS_W-1:0] cb_bj;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
        logic [CODE_W-1:0]       code;
        logic [IDX_W-1:0]        il;
        logic [IDX_W-1:0]        ibl;
        logic [IDX_W-1:0]        ib;
    } pipe_t;

endpackage

// ===== hdl/pgvg_step_div.sv =====
// Shift-subtract divider for the two grid step sizes, one quotient bit per cycle.
module pgvg_step_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pgvg_pkg::SIZE_W-1:0]  size_a,
    input  logic [pgvg_pkg::SIZE_W-1:0]  size_b,
    input  logic [pgvg_pkg::COORD_W-1:0] den_a,
    input  logic [pgvg_pkg::COORD_W-1:0] den_b,
    output logic                        busy,
    output logic [pgvg_pkg::SIZE_W-1:0]  step_a,
    output logic [pgvg_pkg::SIZE_W-1:0]  step_b
);
    import pgvg_pkg::*;

    logic                load_reg;
    logic                busy_reg;
    logic [4:0]          cnt_reg;
    logic [SIZE_W-1:0]   quo_a_reg, quo_b_reg;
    logic [COORD_W-1:0]  rem_a_reg, rem_b_reg;
    logic [COORD_W:0]    step_a_next, step_b_next;

    // returns {remainder, quotient bit}
    function automatic logic [COORD_W:0] div_bit(input logic [COORD_W-1:0] rem,
                                                 input logic                nb,
                                                 input logic [COORD_W-1:0] den);
        logic [COORD_W:0] cand;
        logic [COORD_W:0] diff;
        cand = {rem, nb};
        diff = cand - {1'b0, den};
        if (cand >= {1'b0, den})
            div_bit = {diff[COORD_W-1:0], 1'b1};
        else
            div_bit = {cand[COORD_W-1:0], 1'b0};
    endfunction

    assign step_a_next = div_bit(rem_a_reg, quo_a_reg[SIZE_W-1], den_a);
    assign step_b_next = div_bit(rem_b_reg, quo_b_reg[SIZE_W-1], den_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg <= 1'b1;
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            load_reg <= 1'b1;
            busy_reg <= 1'b1;
        end
        else if (load_reg)
        begin
            load_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'(SIZE_W - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_reg)
        begin
            quo_a_reg <= size_a;
            quo_b_reg <= size_b;
            rem_a_reg <= '0;
            rem_b_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_a_reg <= {quo_a_reg[SIZE_W-2:0], step_a_next[0]};
            quo_b_reg <= {quo_b_reg[SIZE_W-2:0], step_b_next[0]};
            rem_a_reg <= step_a_next[COORD_W:1];
            rem_b_reg <= step_b_next[COORD_W:1];
        end
    end

    assign busy   = busy_reg;
    assign step_a = quo_a_reg;
    assign step_b = quo_b_reg;

endmodule

// ===== hdl/pgvg_tex_div.sv =====
// Pipelined restoring divider for texture coordinates, up to STEPS_PER_STAGE quotient bits per stage.
module pgvg_tex_div (
    input  logic                              clk,
    input  logic [pgvg_pkg::NUM_STAGES-1:0]   en,
    input  logic [pgvg_pkg::COORD_W-1:0]      num,
    input  logic [pgvg_pkg::COORD_W-1:0]      den,
    output logic [pgvg_pkg::TEX_W-1:0]        quo
);
    import pgvg_pkg::*;

    logic [COORD_W-1:0] rem_reg  [NUM_STAGES];
    logic [TEX_W-1:0]   quo_reg  [NUM_STAGES];
    logic [COORD_W-1:0] rem_next [NUM_STAGES];
    logic [TEX_W-1:0]   quo_next [NUM_STAGES];

    // num <= den, so num>>1 is already below den: start there and shift in num[0]
    // then FRAC_BITS zeros.
    always_comb
    begin
        logic [COORD_W-1:0] r;
        logic [TEX_W-1:0]   q;
        logic [COORD_W:0]   cand;
        logic [COORD_W:0]   diff;
        for (int s = 0; s < NUM_STAGES; s++)
        begin
            if (s == 0)
            begin
                r = {1'b0, num[COORD_W-1:1]};
                q = '0;
            end
            else
            begin
                r = rem_reg[s-1];
                q = quo_reg[s-1];
            end
            for (int j = 0; j < STEPS_PER_STAGE; j++)
            begin
                if (s * STEPS_PER_STAGE + j < TEX_STEPS)
                begin
                    cand = {r, (s == 0 && j == 0) ? num[0] : 1'b0};
                    diff = cand - {1'b0, den};
                    if (cand >= {1'b0, den})
                    begin
                        r = diff[COORD_W-1:0];
                        q = {q[TEX_W-2:0], 1'b1};
                    end
                    else
                    begin
                        r = cand[COORD_W-1:0];
                        q = {q[TEX_W-2:0], 1'b0};
                    end
                end
            end
            rem_next[s] = r;
            quo_next[s] = q;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NUM_STAGES; s++)
        begin
            if (en[s])
            begin
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
            end
        end
    end

    assign quo = quo_reg[NUM_STAGES-1];

endmodule

// ===== hdl/plane_grid_vertex_generator.sv =====
// A result passes through 6 register stages. Throughput: one vertex per cycle unless
// stalled; stages advance independently so bubbles close up.
// The tex divider is the deepest path and sets the stage count (3 quotient bits/stage).
// Reset restores default registers; then, and after every config write, input is
// stalled while the bit-serial step divider recomputes the grid step sizes.
module plane_grid_vertex_generator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pgvg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [31:0]                          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [pgvg_pkg::COORD_W-1:0]         column,
    input  logic [pgvg_pkg::COORD_W-1:0]         row,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [pgvg_pkg::POS_W-1:0]    pos_x,
    output logic signed [pgvg_pkg::POS_W-1:0]    pos_y,
    output logic signed [pgvg_pkg::POS_W-1:0]    pos_z,
    output logic [pgvg_pkg::TEX_W-1:0]           tex_u,
    output logic [pgvg_pkg::TEX_W-1:0]           tex_v,
    output logic [pgvg_pkg::CODE_W-1:0]          normal_code,
    output logic [pgvg_pkg::IDX_W-1:0]           vertex_index,
    output logic                                 emits_quad,
    output logic [pgvg_pkg::IDX_W-1:0]           idx_left,
    output logic [pgvg_pkg::IDX_W-1:0]           idx_below_left,
    output logic [pgvg_pkg::IDX_W-1:0]           idx_below,
    output logic [1:0]                           status
);
    import pgvg_pkg::*;

    logic [SIZE_W-1:0]       size_x_reg, size_y_reg;
    logic [SAMP_W-1:0]       samples_x_reg, samples_y_reg;
    logic [2:0]              plane_axis_reg;
    logic signed [POS_W-1:0] plane_offset_reg;

    logic [SAMP_W-1:0]       sx_c, sy_c;
    logic [COORD_W-1:0]      dx, dy;
    logic signed [POS_W-1:0] corner_a, corner_b;
    logic                    cfg_xfer;
    logic                    step_busy;
    logic [SIZE_W-1:0]       step_a, step_b;

    logic [NUM_STAGES-1:0]   vld_reg;
    logic [NUM_STAGES-1:0]   can_load;
    pipe_t                   pipe_reg  [NUM_STAGES];
    pipe_t                   pipe_next [NUM_STAGES];
    logic                    in_xfer;
    logic [TEX_W-1:0]        quo_u, quo_v;

    function automatic logic signed [POS_W-1:0] sat_add(input logic signed [POS_W-1:0] c,
                                                        input logic [SIZE_W-1:0]       v);
        logic signed [POS_W:0] s;
        s = {c[POS_W-1], c} + $signed({2'b00, v});
        if (s > $signed({2'b00, {(POS_W-1){1'b1}}}))
            sat_add = {1'b0, {(POS_W-1){1'b1}}};
        else if (s < $signed({2'b11, {(POS_W-1){1'b0}}}))
            sat_add = {1'b1, {(POS_W-1){1'b0}}};
        else
            sat_add = s[POS_W-1:0];
    endfunction

    // configuration registers
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg       <= 31'd65536;
            size_y_reg       <= 31'd65536;
            samples_x_reg    <= 13'd2;
            samples_y_reg    <= 13'd2;
            plane_axis_reg   <= AX_XZ;
            plane_offset_reg <= '0;
        end
        else if (cfg_xfer)
        begin
            case (cfg_index)
                REG_SIZE_X:       size_x_reg       <= cfg_data[SIZE_W-1:0];
                REG_SIZE_Y:       size_y_reg       <= cfg_data[SIZE_W-1:0];
                REG_SAMPLES_X:    samples_x_reg    <= cfg_data[SAMP_W-1:0];
                REG_SAMPLES_Y:    samples_y_reg    <= cfg_data[SAMP_W-1:0];
                REG_PLANE_AXIS:   plane_axis_reg   <= cfg_data[2:0];
                REG_PLANE_OFFSET: plane_offset_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    assign sx_c = (samples_x_reg > SAMP_W'(MAX_SAMPLES)) ? SAMP_W'(MAX_SAMPLES) : samples_x_reg;
    assign sy_c = (samples_y_reg > SAMP_W'(MAX_SAMPLES)) ? SAMP_W'(MAX_SAMPLES) : samples_y_reg;
    assign dx   = COORD_W'(sx_c - 13'd1);
    assign dy   = COORD_W'(sy_c - 13'd1);
    assign corner_a = -$signed({2'b00, size_x_reg[SIZE_W-1:1]});
    assign corner_b = -$signed({2'b00, size_y_reg[SIZE_W-1:1]});

    pgvg_step_div u_step_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cfg_xfer),
        .size_a (size_x_reg),
        .size_b (size_y_reg),
        .den_a  (dx),
        .den_b  (dy),
        .busy   (step_busy),
        .step_a (step_a),
        .step_b (step_b)
    );

    // per-stage advance: a stage loads when empty or when its content moves on
    always_comb
    begin
        can_load[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || !out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
            can_load[k] = !vld_reg[k] || can_load[k+1];
    end

    assign in_stall = step_busy || !can_load[0];
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        // stage 0: classify point, multiply
        pipe_next[0]        = pipe_reg[0];
        pipe_next[0].col    = column;
        pipe_next[0].row    = row;
        if (sx_c < 13'd2 || sy_c < 13'd2)
            pipe_next[0].status = ST_TOO_SMALL;
        else if ({1'b0, column} >= sx_c || {1'b0, row} >= sy_c)
            pipe_next[0].status = ST_OUTSIDE;
        else
            pipe_next[0].status = ST_OK;
        pipe_next[0].quad = (column != '0) && ({1'b0, row} < sy_c - 13'd1);
        pipe_next[0].ai   = SIZE_W'(step_a * column);
        pipe_next[0].bj   = SIZE_W'(step_b * row);
        pipe_next[0].vid  = IDX_W'(row) * IDX_W'(sx_c);

        // stage 1: corner sums with saturation
        pipe_next[1]       = pipe_reg[0];
        pipe_next[1].ca_ai = sat_add(corner_a, pipe_reg[0].ai);
        pipe_next[1].cb_ai = sat_add(corner_b, pipe_reg[0].ai);
        pipe_next[1].ca_bj = sat_add(corner_a, pipe_reg[0].bj);
        pipe_next[1].cb_bj = sat_add(corner_b, pipe_reg[0].bj);
        pipe_next[1].vid   = pipe_reg[0].vid + IDX_W'(pipe_reg[0].col);

        // stage 2: orientation select, quad indices, clear on bad status
        pipe_next[2] = pipe_reg[1];
        case (plane_axis_reg)
            AX_XY:
            begin
                pipe_next[2].px   = pipe_reg[1].ca_bj;
                pipe_next[2].py   = pipe_reg[1].cb_ai;
                pipe_next[2].pz   = plane_offset_reg;
                pipe_next[2].code = NRM_POS_Z;
            end
            AX_YX:
            begin
                pipe_next[2].px   = pipe_reg[1].ca_ai;
                pipe_next[2].py   = pipe_reg[1].cb_bj;
                pipe_next[2].pz   = plane_offset_reg;
                pipe_next[2].code = NRM_NEG_Z;
            end
            AX_YZ:
            begin
                pipe_next[2].px   = plane_offset_reg;
                pipe_next[2].py   = pipe_reg[1].cb_bj;
                pipe_next[2].pz   = pipe_reg[1].ca_ai;
                pipe_next[2].code = NRM_POS_X;
            end
            AX_ZY:
            begin
                pipe_next[2].px   = plane_offset_reg;
                pipe_next[2].py   = pipe_reg[1].cb_ai;
                pipe_next[2].pz   = pipe_reg[1].ca_bj;
                pipe_next[2].code = NRM_NEG_X;
            end
            AX_ZX:
            begin
                pipe_next[2].px   = pipe_reg[1].ca_bj;
                pipe_next[2].py   = plane_offset_reg;
                pipe_next[2].pz   = pipe_reg[1].cb_ai;
                pipe_next[2].code = NRM_NEG_Y;
            end
            default:
            begin
                pipe_next[2].px   = pipe_reg[1].ca_ai;
                pipe_next[2].py   = plane_offset_reg;
                pipe_next[2].pz   = pipe_reg[1].cb_bj;
                pipe_next[2].code = NRM_POS_Y;
            end
        endcase
        pipe_next[2].il  = pipe_reg[1].vid - 24'd1;
        pipe_next[2].ibl = pipe_reg[1].vid - 24'd1 + IDX_W'(sx_c);
        pipe_next[2].ib  = pipe_reg[1].vid + IDX_W'(sx_c);
        if (pipe_reg[1].status != ST_OK || !pipe_reg[1].quad)
        begin
            pipe_next[2].il   = '0;
            pipe_next[2].ibl  = '0;
            pipe_next[2].ib   = '0;
            pipe_next[2].quad = 1'b0;
        end
        if (pipe_reg[1].status != ST_OK)
        begin
            pipe_next[2].px   = '0;
            pipe_next[2].py   = '0;
            pipe_next[2].pz   = '0;
            pipe_next[2].code = '0;
            pipe_next[2].vid  = '0;
        end

        // remaining stages only wait for the texture divider
        for (int k = 3; k < NUM_STAGES; k++)
            pipe_next[k] = pipe_reg[k-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (can_load[0])
                vld_reg[0] <= in_xfer;
            for (int k = 1; k < NUM_STAGES; k++)
                if (can_load[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_STAGES; k++)
            if (can_load[k])
                pipe_reg[k] <= pipe_next[k];
    end

    pgvg_tex_div u_tex_u (
        .clk (clk),
        .en  (can_load),
        .num (column),
        .den (dx),
        .quo (quo_u)
    );

    pgvg_tex_div u_tex_v (
        .clk (clk),
        .en  (can_load),
        .num (row),
        .den (dy),
        .quo (quo_v)
    );

    assign out_valid      = vld_reg[NUM_STAGES-1];
    assign pos_x          = pipe_reg[NUM_STAGES-1].px;
    assign pos_y          = pipe_reg[NUM_STAGES-1].py;
    assign pos_z          = pipe_reg[NUM_STAGES-1].pz;
    assign tex_u          = (pipe_reg[NUM_STAGES-1].status == ST_OK) ? quo_u : '0;
    assign tex_v          = (pipe_reg[NUM_STAGES-1].status == ST_OK) ? quo_v : '0;
    assign normal_code    = pipe_reg[NUM_STAGES-1].code;
    assign vertex_index   = pipe_reg[NUM_STAGES-1].vid;
    assign emits_quad     = pipe_reg[NUM_STAGES-1].quad;
    assign idx_left       = pipe_reg[NUM_STAGES-1].il;
    assign idx_below_left = pipe_reg[NUM_STAGES-1].ibl;
    assign idx_below      = pipe_reg[NUM_STAGES-1].ib;
    assign status         = pipe_reg[NUM_STAGES-1].status;

    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        step_busy |-> in_stall)
        else $error("input taken while step sizes are being recomputed");

    a_bad_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |->
            (pos_x == '0 && pos_z == '0 && tex_u == '0 && vertex_index == '0))
        else $error("fields not cleared on error status");

    a_tex_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OK) |-> (tex_u <= 17'd65536 && tex_v <= 17'd65536))
        else $error("texture coordinate above one");

    a_quad_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && emits_quad) |-> (status == ST_OK))
        else $error("quad flagged on invalid vertex");

endmodule
